[hdl/closed_catmull_rom_point_eval_defines.svh]
// Assertion macros for the closed-loop curve point evaluator.
// Used by the top level; they expand to nothing under SYNTHESIS.
`ifndef CLOSED_CATMULL_ROM_POINT_EVAL_DEFINES_SVH
`define CLOSED_CATMULL_ROM_POINT_EVAL_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define CRP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("crp assertion failed");
// Next-cycle implication
`define CRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("crp assertion failed");
`else
`define CRP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define CRP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hdl/crp_pkg.sv]
// Shared types and constants of the closed-loop curve point evaluator.
// No dependencies; imported by every module of the block.
package crp_pkg;

    localparam int MaxPoints   = 64;
    localparam int IdxBits     = $clog2(MaxPoints);
    localparam int CountBits   = IdxBits + 1;
    localparam int CoordBits   = 32;
    localparam int FracBits    = 16;
    localparam int WeightBits  = FracBits + 4;
    localparam int ProdBits    = CoordBits + WeightBits;
    localparam int SumBits     = ProdBits + 2;
    localparam int QueueDepth  = 4;
    localparam int QueuePtrBits = $clog2(QueueDepth);

    typedef logic [1:0]                   status_t;
    typedef logic signed [CoordBits-1:0]  coord_t;
    typedef logic [IdxBits-1:0]           idx_t;
    typedef logic [CountBits-1:0]         count_t;
    typedef logic [FracBits-1:0]          frac_t;

    // Request operations
    localparam logic OpStore = 1'b0;
    localparam logic OpEval  = 1'b1;

    // Result status codes, also used as the request kind inside the block
    localparam status_t StatusEval     = 2'd0;
    localparam status_t StatusStored   = 2'd1;
    localparam status_t StatusNoPoints = 2'd2;

    // Classified request as it travels from front to back
    typedef struct packed {
        status_t kind;
        idx_t    slot;
        coord_t  x;
        coord_t  y;
        coord_t  z;
        frac_t   t;
        idx_t    idx0;
        idx_t    idx1;
        idx_t    idx2;
        idx_t    idx3;
    } req_t;

endpackage

[hdl/crp_front.sv]
// Front end: accepts requests, classifies them and finds segment, t and neighbor slots.
// Depends on crp_pkg.
module crp_front (
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_op,
    input  crp_pkg::idx_t   s_point_index,
    input  crp_pkg::coord_t s_in_x,
    input  crp_pkg::coord_t s_in_y,
    input  crp_pkg::coord_t s_in_z,
    input  crp_pkg::frac_t  s_curve_pos,
    input  crp_pkg::count_t n_points,
    input  logic            q_full,
    output logic            q_push,
    output crp_pkg::req_t   q_req
);
    import crp_pkg::*;

    count_t                        n_eff;
    count_t                        n_m1;
    idx_t                          last;
    logic [FracBits+CountBits-1:0] scaled;
    idx_t                          seg;
    idx_t                          nb0;
    idx_t                          nb2;
    idx_t                          nb3;

    // Accept while the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Clamp the point count to the table size
    assign n_eff = (n_points > count_t'(MaxPoints)) ? count_t'(MaxPoints) : n_points;
    assign n_m1  = n_eff - count_t'(1);
    assign last  = n_m1[IdxBits-1:0];

    // Split position * count into segment and local t
    assign scaled = {{CountBits{1'b0}}, s_curve_pos} * {{FracBits{1'b0}}, n_eff};
    assign seg    = scaled[FracBits +: IdxBits];

    // Wrap neighbor slots around the loop
    assign nb0 = (seg == '0)   ? last : seg - idx_t'(1);
    assign nb2 = (seg == last) ? '0   : seg + idx_t'(1);
    assign nb3 = (nb2 == last) ? '0   : nb2 + idx_t'(1);

    always_comb begin
        q_req      = '0;
        q_req.slot = s_point_index;
        q_req.x    = s_in_x;
        q_req.y    = s_in_y;
        q_req.z    = s_in_z;
        q_req.t    = scaled[FracBits-1:0];
        q_req.idx0 = nb0;
        q_req.idx1 = seg;
        q_req.idx2 = nb2;
        q_req.idx3 = nb3;
        if (s_op == OpStore) begin
            q_req.kind = StatusStored;
        end else if (n_eff == '0) begin
            q_req.kind = StatusNoPoints;
        end else begin
            q_req.kind = StatusEval;
        end
    end

endmodule

[hdl/crp_queue.sv]
// Short request queue between front and back end.
// Depends on crp_pkg.
module crp_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  crp_pkg::req_t push_req,
    output logic          full,
    output logic          head_valid,
    output crp_pkg::req_t head_req,
    input  logic          pop
);
    import crp_pkg::*;

    req_t                    entries_reg [QueueDepth];
    logic [QueuePtrBits-1:0] wr_ptr_reg;
    logic [QueuePtrBits-1:0] rd_ptr_reg;
    logic [QueuePtrBits:0]   count_reg;
    logic [QueuePtrBits:0]   count_next;

    assign full       = (count_reg == (QueuePtrBits+1)'(QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head_req   = entries_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Hold request payloads
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

[hdl/crp_back.sv]
// Back end: point table, basis weights, per-axis blend and saturation, output register.
// Depends on crp_pkg.
module crp_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            head_valid,
    input  crp_pkg::req_t   head_req,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output crp_pkg::status_t m_status,
    output crp_pkg::coord_t m_out_x,
    output crp_pkg::coord_t m_out_y,
    output crp_pkg::coord_t m_out_z
);
    import crp_pkg::*;

    localparam int W1 = WeightBits + 1;
    localparam logic signed [W1-1:0] TwoOne = W1'(2 ** (FracBits + 1));
    localparam logic signed [SumBits-1:0] SatHi =
        {{(SumBits-CoordBits+1){1'b0}}, {(CoordBits-1){1'b1}}};
    localparam logic signed [SumBits-1:0] SatLo =
        {{(SumBits-CoordBits+1){1'b1}}, {(CoordBits-1){1'b0}}};

    logic en;

    // Point tables, two copies so four slots read per cycle while the back end advances
    coord_t mem_lo [3][MaxPoints];
    coord_t mem_hi [3][MaxPoints];
    coord_t head_coord [3];

    // Stage 1: table read, t squared
    logic    v1_reg;
    status_t kind1_reg;
    frac_t   t1_reg;
    frac_t   tt1_reg;
    coord_t  p1_reg [3][4];
    logic [2*FracBits-1:0] tt_full;

    // Stage 2: t cubed
    logic    v2_reg;
    status_t kind2_reg;
    frac_t   t2_reg;
    frac_t   tt2_reg;
    frac_t   ttt2_reg;
    coord_t  p2_reg [3][4];
    logic [2*FracBits-1:0] ttt_full;

    // Stage 3: basis weights
    logic    v3_reg;
    status_t kind3_reg;
    logic signed [WeightBits-1:0] w3_reg [4];
    coord_t  p3_reg [3][4];
    logic signed [W1-1:0] e_t;
    logic signed [W1-1:0] e_tt;
    logic signed [W1-1:0] e_ttt;
    logic signed [W1-1:0] wsum [4];

    // Stage 4: products
    logic    v4_reg;
    status_t kind4_reg;
    logic signed [ProdBits-1:0] prod4_reg [3][4];

    // Stage 5: sums
    logic    v5_reg;
    status_t kind5_reg;
    logic signed [SumBits-1:0] sum5_reg [3];
    logic signed [SumBits-1:0] shifted [3];
    coord_t  sat [3];

    // Output register
    logic    m_valid_reg;
    status_t m_status_reg;
    coord_t  out_reg [3];

    // Advance the whole back end unless a result waits to be taken
    assign en  = !m_valid_reg || m_ready;
    assign pop = en && head_valid;

    assign head_coord[0] = head_req.x;
    assign head_coord[1] = head_req.y;
    assign head_coord[2] = head_req.z;

    // Write stores and read neighbors in the same stage to keep request order
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 3; a++) begin
                if (head_valid && (head_req.kind == StatusStored)) begin
                    mem_lo[a][head_req.slot] <= head_coord[a];
                    mem_hi[a][head_req.slot] <= head_coord[a];
                end
                p1_reg[a][0] <= mem_lo[a][head_req.idx0];
                p1_reg[a][1] <= mem_lo[a][head_req.idx1];
                p1_reg[a][2] <= mem_hi[a][head_req.idx2];
                p1_reg[a][3] <= mem_hi[a][head_req.idx3];
            end
        end
    end

    assign tt_full  = head_req.t * head_req.t;
    assign ttt_full = tt1_reg * t1_reg;

    // Form the weights, each rounded toward minus infinity
    assign e_t   = $signed({{(W1-FracBits){1'b0}}, t2_reg});
    assign e_tt  = $signed({{(W1-FracBits){1'b0}}, tt2_reg});
    assign e_ttt = $signed({{(W1-FracBits){1'b0}}, ttt2_reg});

    assign wsum[0] = (e_tt <<< 1) - e_ttt - e_t;
    assign wsum[1] = (e_ttt <<< 1) + e_ttt - (e_tt <<< 2) - e_tt + TwoOne;
    assign wsum[2] = (e_tt <<< 2) - (e_ttt <<< 1) - e_ttt + e_t;
    assign wsum[3] = e_ttt - e_tt;

    // Drop fraction bits and saturate each axis
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            shifted[a] = sum5_reg[a] >>> FracBits;
            if (shifted[a] > SatHi) begin
                sat[a] = SatHi[CoordBits-1:0];
            end else if (shifted[a] < SatLo) begin
                sat[a] = SatLo[CoordBits-1:0];
            end else begin
                sat[a] = shifted[a][CoordBits-1:0];
            end
        end
    end

    // Pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= head_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            m_valid_reg <= v5_reg;
        end
    end

    // Pipeline payload
    always_ff @(posedge aclk) begin
        if (en) begin
            kind1_reg <= head_req.kind;
            t1_reg    <= head_req.t;
            tt1_reg   <= tt_full[2*FracBits-1:FracBits];

            kind2_reg <= kind1_reg;
            t2_reg    <= t1_reg;
            tt2_reg   <= tt1_reg;
            ttt2_reg  <= ttt_full[2*FracBits-1:FracBits];
            p2_reg    <= p1_reg;

            kind3_reg <= kind2_reg;
            p3_reg    <= p2_reg;
            for (int k = 0; k < 4; k++) begin
                w3_reg[k] <= WeightBits'(wsum[k] >>> 1);
            end

            kind4_reg <= kind3_reg;
            for (int a = 0; a < 3; a++) begin
                for (int k = 0; k < 4; k++) begin
                    prod4_reg[a][k] <= w3_reg[k] * p3_reg[a][k];
                end
            end

            kind5_reg <= kind4_reg;
            for (int a = 0; a < 3; a++) begin
                sum5_reg[a] <= SumBits'(prod4_reg[a][0]) + SumBits'(prod4_reg[a][1])
                             + SumBits'(prod4_reg[a][2]) + SumBits'(prod4_reg[a][3]);
            end

            m_status_reg <= kind5_reg;
            for (int a = 0; a < 3; a++) begin
                out_reg[a] <= (kind5_reg == StatusEval) ? sat[a] : '0;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_out_x  = out_reg[0];
    assign m_out_y  = out_reg[1];
    assign m_out_z  = out_reg[2];

endmodule

[hdl/closed_catmull_rom_point_eval.sv]
// Closed-loop curve point evaluator, top level: config register, front, queue, back.
// An accepted request is registered in the queue first. Throughput: one request per cycle
// unless the output stalls; the six-stage back end (table read with t^2, t^3, weights,
// products, sums, saturation) shares one stall driven by the output register.
// Reset (synchronous, active low) clears the point count, queue and valid bits;
// the point table is not cleared and must be written before it is read.
`include "closed_catmull_rom_point_eval_defines.svh"

module closed_catmull_rom_point_eval (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  crp_pkg::count_t  cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_op,
    input  crp_pkg::idx_t    s_point_index,
    input  crp_pkg::coord_t  s_in_x,
    input  crp_pkg::coord_t  s_in_y,
    input  crp_pkg::coord_t  s_in_z,
    input  crp_pkg::frac_t   s_curve_pos,
    output logic             m_valid,
    input  logic             m_ready,
    output crp_pkg::status_t m_status,
    output crp_pkg::coord_t  m_out_x,
    output crp_pkg::coord_t  m_out_y,
    output crp_pkg::coord_t  m_out_z
);
    import crp_pkg::*;

    count_t n_points_reg;
    logic   q_full;
    logic   q_push;
    req_t   q_req;
    logic   head_valid;
    req_t   head_req;
    logic   pop;

    // Point count register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_points_reg <= '0;
        end else if (cfg_valid) begin
            n_points_reg <= cfg_data;
        end
    end

    crp_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_point_index (s_point_index),
        .s_in_x        (s_in_x),
        .s_in_y        (s_in_y),
        .s_in_z        (s_in_z),
        .s_curve_pos   (s_curve_pos),
        .n_points      (n_points_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_req         (q_req)
    );

    crp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_req   (q_req),
        .full       (q_full),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (pop)
    );

    crp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_req   (head_req),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_out_x    (m_out_x),
        .m_out_y    (m_out_y),
        .m_out_z    (m_out_z)
    );

    // Store and no-point results carry zero coordinates
    `CRP_ASSERT_IMPLY(a_non_eval_zero, aclk, aresetn, m_valid && (m_status != StatusEval), (m_out_x == '0) && (m_out_y == '0) && (m_out_z == '0))
    // An evaluated point implies a nonzero point count
    `CRP_ASSERT_IMPLY(a_eval_has_points, aclk, aresetn, m_valid && (m_status == StatusEval), n_points_reg != '0)
    // Reset leaves the block empty and ready for requests
    `CRP_ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_valid && s_ready)

endmodule

[test/closed_catmull_rom_point_eval_check.sv]
// Result checker for the closed-loop curve point evaluator: tracks the point
// table and point count, predicts every result and compares it on delivery.
// Depends on crp_pkg for port types, operation and status codes.
`timescale 1ns / 100ps

module closed_catmull_rom_point_eval_check (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  crp_pkg::count_t  cfg_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic             s_op,
    input  crp_pkg::idx_t    s_point_index,
    input  crp_pkg::coord_t  s_in_x,
    input  crp_pkg::coord_t  s_in_y,
    input  crp_pkg::coord_t  s_in_z,
    input  crp_pkg::frac_t   s_curve_pos,
    input  logic             m_valid,
    input  logic             m_ready,
    input  crp_pkg::status_t m_status,
    input  crp_pkg::coord_t  m_out_x,
    input  crp_pkg::coord_t  m_out_y,
    input  crp_pkg::coord_t  m_out_z,
    input  logic             end_check,
    output int               fail_count,
    output int               pending_count
);
    import crp_pkg::*;

    localparam longint CoordMax = (longint'(1) <<< (CoordBits - 1)) - 1;
    localparam longint CoordMin = -CoordMax - 1;

    typedef struct packed {
        status_t status;
        coord_t  x;
        coord_t  y;
        coord_t  z;
    } curve_result_t;

    coord_t        x_points[MaxPoints];
    coord_t        y_points[MaxPoints];
    coord_t        z_points[MaxPoints];
    count_t        point_count;
    curve_result_t expected_points[$];
    logic          end_checked = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (fail_count < 100)
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // Weighted sum of four control points on one axis, floored and saturated
    function automatic coord_t blend_axis(input coord_t p[4], input longint w[4]);
        longint acc;
        acc = 0;
        for (int k = 0; k < 4; k++)
            acc += longint'(p[k]) * w[k];
        acc = acc >>> FracBits;
        if (acc > CoordMax)
            acc = CoordMax;
        if (acc < CoordMin)
            acc = CoordMin;
        return coord_t'(acc);
    endfunction

    // Curve point at a global loop position for the current table and count
    function automatic curve_result_t eval_curve_point(input frac_t pos, input count_t count);
        curve_result_t r;
        longint        n_eff, scaled, seg, t, t2, t3;
        longint        w[4];
        int            idx[4];
        coord_t        px[4], py[4], pz[4];
        r = '0;
        r.status = StatusEval;
        n_eff = (count > MaxPoints) ? MaxPoints : count;
        if (n_eff == 0) begin
            r.status = StatusNoPoints;
            return r;
        end
        scaled = longint'(pos) * n_eff;
        seg = scaled >> FracBits;
        t = scaled & ((longint'(1) << FracBits) - 1);
        t2 = (t * t) >> FracBits;
        t3 = (t2 * t) >> FracBits;
        // basis weights, each halved with rounding toward minus infinity
        w[0] = (2 * t2 - t3 - t) >>> 1;
        w[1] = (3 * t3 - 5 * t2 + (longint'(2) << FracBits)) >>> 1;
        w[2] = (4 * t2 - 3 * t3 + t) >>> 1;
        w[3] = (t3 - t2) >>> 1;
        for (int k = 0; k < 4; k++) begin
            idx[k] = int'((seg + n_eff - 1 + k) % n_eff);
            px[k] = x_points[idx[k]];
            py[k] = y_points[idx[k]];
            pz[k] = z_points[idx[k]];
        end
        r.x = blend_axis(px, w);
        r.y = blend_axis(py, w);
        r.z = blend_axis(pz, w);
        return r;
    endfunction

    always @(posedge aclk) begin
        curve_result_t want;
        if (!aresetn) begin
            expected_points.delete();
            point_count = '0;
            pending_count <= 0;
        end else begin
            // retire a delivered result against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_points.size() == 0) begin
                    report_mismatch("unexpected result, status", longint'(m_status), 0);
                end else begin
                    want = expected_points.pop_front();
                    if (m_status !== want.status)
                        report_mismatch("status", longint'(m_status), longint'(want.status));
                    if (m_out_x !== want.x)
                        report_mismatch("out_x", longint'(m_out_x), longint'(want.x));
                    if (m_out_y !== want.y)
                        report_mismatch("out_y", longint'(m_out_y), longint'(want.y));
                    if (m_out_z !== want.z)
                        report_mismatch("out_z", longint'(m_out_z), longint'(want.z));
                end
            end

            if (cfg_valid && cfg_ready)
                point_count = cfg_data;

            // predict the result of an accepted request
            if (s_valid && s_ready) begin
                if (s_op == OpStore) begin
                    x_points[s_point_index] = s_in_x;
                    y_points[s_point_index] = s_in_y;
                    z_points[s_point_index] = s_in_z;
                    want = '0;
                    want.status = StatusStored;
                end else begin
                    want = eval_curve_point(s_curve_pos, point_count);
                end
                expected_points.insert(expected_points.size(), want);
            end

            if (end_check && !end_checked) begin
                end_checked = 1'b1;
                if (expected_points.size() != 0)
                    report_mismatch("results never delivered", 0,
                                    longint'(expected_points.size()));
            end

            pending_count <= expected_points.size();
        end
    end

endmodule

[test/closed_catmull_rom_point_eval_tb.sv]
// Testbench top for the closed-loop curve point evaluator: clock, reset,
// request and result traffic with random idling, and the final verdict.
// Depends on crp_pkg, the block and closed_catmull_rom_point_eval_check.
`timescale 1ns / 100ps

module closed_catmull_rom_point_eval_tb;
    import crp_pkg::*;

    localparam int          LatencyCycles  = 7;
    localparam int          LongHoldCycles = 300;
    localparam int unsigned CycleLimit     = 400000;
    localparam coord_t      CoordHi = {1'b0, {(CoordBits - 1){1'b1}}};
    localparam coord_t      CoordLo = {1'b1, {(CoordBits - 1){1'b0}}};

    logic    aclk;
    logic    aresetn;
    logic    cfg_valid;
    logic    cfg_ready;
    count_t  cfg_data;
    logic    s_valid;
    logic    s_ready;
    logic    s_op;
    idx_t    s_point_index;
    coord_t  s_in_x;
    coord_t  s_in_y;
    coord_t  s_in_z;
    frac_t   s_curve_pos;
    logic    m_valid;
    logic    m_ready;
    status_t m_status;
    coord_t  m_out_x;
    coord_t  m_out_y;
    coord_t  m_out_z;

    logic        end_check = 1'b0;
    logic        hold_off_req = 1'b0;
    int          fail_count;
    int          pending_count;
    int          sender_idle_pct = 0;
    int unsigned cycle_count;

    closed_catmull_rom_point_eval u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_point_index (s_point_index),
        .s_in_x        (s_in_x),
        .s_in_y        (s_in_y),
        .s_in_z        (s_in_z),
        .s_curve_pos   (s_curve_pos),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_out_z       (m_out_z)
    );

    closed_catmull_rom_point_eval_check u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_point_index (s_point_index),
        .s_in_x        (s_in_x),
        .s_in_y        (s_in_y),
        .s_in_z        (s_in_z),
        .s_curve_pos   (s_curve_pos),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_out_z       (m_out_z),
        .end_check     (end_check),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Bound the run
    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CycleLimit);
        $display("FAIL");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(4))
                    0: return CoordHi;
                    1: return CoordLo;
                    2: return '0;
                    3: return '1;
                    default: return coord_t'(1);
                endcase
            end
            1, 2: return coord_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic frac_t pick_pos();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return frac_t'($urandom);
        endcase
    endfunction

    // Result side: random back-pressure in changing modes, one long hold-off on request
    initial begin : result_sink
        int   idle_pct;
        int   gap_left;
        int   mode_cycles;
        logic hold_off_done;
        m_ready <= 1'b0;
        idle_pct = 0;
        gap_left = 0;
        mode_cycles = 0;
        hold_off_done = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LongHoldCycles) @(posedge aclk);
            end else begin
                if (mode_cycles == 0) begin
                    case ($urandom_range(3))
                        0: idle_pct = 0;
                        1: idle_pct = 15;
                        2: idle_pct = 40;
                        default: idle_pct = 70;
                    endcase
                    mode_cycles = $urandom_range(32, 128);
                end
                mode_cycles--;
                if (gap_left > 0) begin
                    gap_left--;
                    m_ready <= 1'b0;
                end else if ($urandom_range(99) < idle_pct) begin
                    gap_left = gap_length() - 1;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // Offer one request and hold it until accepted
    task automatic send_request(input logic op, input idx_t slot, input coord_t x,
                                input coord_t y, input coord_t z, input frac_t pos);
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? gap_length() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_op          <= op;
        s_point_index <= slot;
        s_in_x        <= x;
        s_in_y        <= y;
        s_in_z        <= z;
        s_curve_pos   <= pos;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random_item(input int store_pct);
        if ($urandom_range(99) < store_pct)
            send_request(OpStore, idx_t'($urandom), pick_coord(), pick_coord(), pick_coord(),
                         frac_t'($urandom));
        else
            send_request(OpEval, idx_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                         coord_t'($urandom), pick_pos());
    endtask

    // Stop offering and wait until every predicted result has arrived
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic write_point_count(input count_t count);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic run_phase(input count_t count, input int items, input int store_pct,
                             input int idle_pct, input bit with_hold);
        write_point_count(count);
        sender_idle_pct = idle_pct;
        if (with_hold)
            hold_off_req <= 1'b1;
        repeat (items) send_random_item(store_pct);
    endtask

    initial begin : stimulus
        aresetn       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        s_valid       <= 1'b0;
        s_op          <= OpStore;
        s_point_index <= '0;
        s_in_x        <= '0;
        s_in_y        <= '0;
        s_in_z        <= '0;
        s_curve_pos   <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // count is zero out of reset: evaluations report no points
        send_request(OpEval, '0, '0, '0, '0, '0);
        send_request(OpEval, '1, CoordHi, CoordLo, '1, '1);

        // four-point loop with full-scale coordinates, plus the last slot
        send_request(OpStore, idx_t'(0), CoordLo, CoordHi, '0, '0);
        send_request(OpStore, idx_t'(1), CoordHi, CoordLo, '1, '1);
        send_request(OpStore, idx_t'(2), CoordHi, CoordLo, coord_t'(1), '0);
        send_request(OpStore, idx_t'(3), CoordLo, CoordHi, CoordHi, '0);
        send_request(OpStore, '1, '1, '0, CoordLo, '1);

        // segment starts, loop wrap, and mid-segment overshoot into saturation
        write_point_count(count_t'(4));
        send_request(OpEval, '0, '0, '0, '0, 16'h0000);
        send_request(OpEval, '0, '0, '0, '0, 16'hFFFF);
        send_request(OpEval, '0, '0, '0, '0, 16'h6000);
        send_request(OpEval, '0, '0, '0, '0, 16'h2000);
        send_request(OpEval, '0, '0, '0, '0, 16'h4000);
        send_request(OpEval, '0, '0, '0, '0, 16'h0001);
        send_request(OpEval, '0, '0, '0, '0, 16'hA000);

        // single point: every neighbor is the same slot
        write_point_count(count_t'(1));
        send_request(OpEval, '0, '0, '0, '0, 16'h8000);
        send_request(OpEval, '0, '0, '0, '0, 16'hFFFF);

        // fill the whole table before any larger count is used
        sender_idle_pct = 20;
        for (int k = 0; k < MaxPoints; k++)
            send_request(OpStore, idx_t'(k), pick_coord(), pick_coord(), pick_coord(),
                         frac_t'($urandom));

        run_phase(count_t'(127), 50, 20, 10, 1'b0);
        run_phase(count_t'(MaxPoints), 70, 20, 0, 1'b1);
        run_phase(count_t'(3), 50, 25, 30, 1'b0);
        run_phase(count_t'(0), 25, 30, 20, 1'b0);
        run_phase(count_t'(MaxPoints + 1), 40, 20, 10, 1'b0);
        run_phase(count_t'(2), 40, 20, 50, 1'b0);
        run_phase(count_t'($urandom_range(1, MaxPoints)), 60, 20, 10, 1'b0);
        run_phase(count_t'(MaxPoints), 60, 20, 30, 1'b0);

        // drain, let the pipeline settle, then check for leftovers
        wait_for_results();
        repeat (3 * LatencyCycles) @(posedge aclk);
        end_check <= 1'b1;
        repeat (2) @(posedge aclk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
